### design/json_string_unescape_defines.svh
// Assertion macros shared by the string unescaper modules.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/jsu_pkg.sv
// Types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    END_QUOTE    = 2'd0,
    END_ZERO     = 2'd1,
    END_NO_QUOTE = 2'd2
  } end_status_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_U = 8'h75;

  // Output buffer: room for the widest burst plus one waiting result.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned BufDepth = MaxResults + 1;
  localparam int unsigned BufCntW = $clog2(BufDepth + 1);
  localparam int unsigned NumW = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [7:0]  data;
    logic        has_byte;
    logic        last;
    end_status_e status;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [NumW-1:0]       num;
  } dec_t;

  function automatic res_t mk_data(input logic [7:0] b);
    res_t r;
    r.data = b;
    r.has_byte = 1'b1;
    r.last = 1'b0;
    r.status = END_QUOTE;
    return r;
  endfunction

  function automatic res_t mk_end(input end_status_e st);
    res_t r;
    r.data = 8'h00;
    r.has_byte = 1'b0;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

  // Non-hex characters count as digit zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
    else if (c inside {[8'h61:8'h66]}) v = c - 8'h57;
    else if (c inside {[8'h41:8'h46]}) v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic dec_t utf8_encode(input logic [15:0] cp);
    dec_t d;
    d = '0;
    if (cp < 16'h0080) begin
      d.res[0] = mk_data(cp[7:0]);
      d.num = NumW'(1);
    end else if (cp < 16'h0800) begin
      d.res[0] = mk_data(8'hC0 | {3'b000, cp[10:6]});
      d.res[1] = mk_data(8'h80 | {2'b00, cp[5:0]});
      d.num = NumW'(2);
    end else begin
      d.res[0] = mk_data(8'hE0 | {4'h0, cp[15:12]});
      d.res[1] = mk_data(8'h80 | {2'b00, cp[11:6]});
      d.res[2] = mk_data(8'h80 | {2'b00, cp[5:0]});
      d.num = NumW'(3);
    end
    return d;
  endfunction

endpackage

### design/json_string_unescape.sv
// Top level of the JSON string unescaper: decoder plus output buffer.
//
// Streams one JSON string literal, opening quote first, and emits its
// unescaped bytes, ending each string with one result that carries last and
// a status. One byte is taken per cycle: a byte is accepted whenever the
// four-entry output buffer holds at most one result, so plain text and
// short escapes flow at one byte per clock while the output is ready. A
// \uXXXX escape that encodes to two or three UTF-8 bytes puts a burst into
// the buffer, and input then stalls while the single output port drains
// it. No result is ever dropped under output backpressure.
`include "json_string_unescape_defines.svh"

module json_string_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_has_byte_o,
  output logic       out_last_o,
  output logic [1:0] out_end_status_o
);

  localparam int unsigned CntW = jsu_pkg::BufCntW;

  jsu_pkg::dec_t     dec;
  jsu_pkg::res_t     slot_q [jsu_pkg::BufDepth];
  jsu_pkg::res_t     slot_d [jsu_pkg::BufDepth];
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   count_mid;
  logic              in_fire;
  logic              pop;

  // Accept only while a full burst still fits.
  assign in_ready_o = (count_q <= CntW'(jsu_pkg::BufDepth - jsu_pkg::MaxResults));
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop = out_valid_o && out_ready_i;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (in_byte_i),
    .dec_o     (dec)
  );

  always_comb begin
    for (int i = 0; i < jsu_pkg::BufDepth - 1; i++) begin
      slot_d[i] = pop ? slot_q[i + 1] : slot_q[i];
    end
    slot_d[jsu_pkg::BufDepth - 1] = slot_q[jsu_pkg::BufDepth - 1];
    count_mid = count_q - CntW'(pop);
    // append new results behind whatever is left after the pop
    for (int i = 0; i < jsu_pkg::BufDepth; i++) begin
      for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
        if (in_fire && (CntW'(k) < CntW'(dec.num)) &&
            (count_mid + CntW'(k) == CntW'(i))) begin
          slot_d[i] = dec.res[k];
        end
      end
    end
    count_d = count_mid + (in_fire ? CntW'(dec.num) : CntW'(0));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jsu_pkg::BufDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_byte_o = slot_q[0].data;
  assign out_has_byte_o = slot_q[0].has_byte;
  assign out_last_o = slot_q[0].last;
  assign out_end_status_o = slot_q[0].status;

  `JSU_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(jsu_pkg::BufDepth), "output buffer overfilled")
  `JSU_ASSERT(a_end_has_no_byte, (out_valid_o && out_last_o) |-> (!out_has_byte_o && out_byte_o == 8'h00), "end result carries a byte")
  `JSU_ASSERT(a_data_status_zero, (out_valid_o && !out_last_o) |-> (out_has_byte_o && out_end_status_o == 2'd0), "data result carries a status")

endmodule

### design/jsu_decode.sv
// Escape decoder: parser state and the results one input byte produces.
`include "json_string_unescape_defines.svh"

module jsu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [7:0]    in_byte_i,
  output jsu_pkg::dec_t dec_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     digits_q, digits_d;
  logic [15:0]    cp_q, cp_d;
  logic [15:0]    cp_full;

  assign cp_full = {cp_q[11:0], jsu_pkg::hex_value(in_byte_i)};

  always_comb begin
    mode_d = mode_q;
    digits_d = digits_q;
    cp_d = cp_q;
    dec_o = '0;
    case (mode_q)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte_i == jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_BODY;
        end else begin
          dec_o.res[0] = jsu_pkg::mk_end(jsu_pkg::END_NO_QUOTE);
          dec_o.num = jsu_pkg::NumW'(1);
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (in_byte_i == jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_IDLE;
          dec_o.res[0] = jsu_pkg::mk_end(jsu_pkg::END_QUOTE);
          dec_o.num = jsu_pkg::NumW'(1);
        end else if (in_byte_i == jsu_pkg::CH_NUL) begin
          mode_d = jsu_pkg::MODE_IDLE;
          dec_o.res[0] = jsu_pkg::mk_end(jsu_pkg::END_ZERO);
          dec_o.num = jsu_pkg::NumW'(1);
        end else if (in_byte_i == jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          dec_o.res[0] = jsu_pkg::mk_data(in_byte_i);
          dec_o.num = jsu_pkg::NumW'(1);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte_i == jsu_pkg::CH_NUL) begin
          mode_d = jsu_pkg::MODE_IDLE;
          dec_o.res[0] = jsu_pkg::mk_end(jsu_pkg::END_ZERO);
          dec_o.num = jsu_pkg::NumW'(1);
        end else if (in_byte_i == jsu_pkg::CH_U) begin
          mode_d = jsu_pkg::MODE_HEX;
          digits_d = 2'd0;
          cp_d = 16'h0000;
        end else begin
          mode_d = jsu_pkg::MODE_BODY;
          dec_o.res[0] = jsu_pkg::mk_data(jsu_pkg::esc_map(in_byte_i));
          dec_o.num = jsu_pkg::NumW'(1);
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (in_byte_i == jsu_pkg::CH_NUL) begin
          // drop the partial code point
          mode_d = jsu_pkg::MODE_IDLE;
          digits_d = 2'd0;
          dec_o.res[0] = jsu_pkg::mk_end(jsu_pkg::END_ZERO);
          dec_o.num = jsu_pkg::NumW'(1);
        end else if (digits_q == 2'd3) begin
          mode_d = jsu_pkg::MODE_BODY;
          digits_d = 2'd0;
          cp_d = 16'h0000;
          dec_o = jsu_pkg::utf8_encode(cp_full);
        end else begin
          cp_d = cp_full;
          digits_d = digits_q + 2'd1;
        end
      end
      default: begin
        mode_d = jsu_pkg::MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      digits_q <= 2'd0;
      cp_q <= 16'h0000;
    end else if (in_fire_i) begin
      mode_q <= mode_d;
      digits_q <= digits_d;
      cp_q <= cp_d;
    end
  end

  `JSU_ASSERT(a_digits_only_in_hex, (mode_q != jsu_pkg::MODE_HEX) |-> (digits_q == 2'd0), "hex digit count outside hex run")
  `JSU_ASSERT(a_burst_only_from_hex, (dec_o.num > jsu_pkg::NumW'(1)) |-> (mode_q == jsu_pkg::MODE_HEX), "multi-byte burst outside hex run")
  `JSU_ASSERT(a_end_returns_idle, (in_fire_i && dec_o.num != '0 && dec_o.res[0].last) |=> (mode_q == jsu_pkg::MODE_IDLE), "string end did not return to idle")

endmodule
